FILE: rtl/htfp_pkg.sv
// Shared types, constants and helper functions for the hex text fronthaul frame parser.
// Has no dependencies; every other file of the block depends on it.
package htfp_pkg;

  // Field widths of the request and result channels.
  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 5;
  localparam int VALUE_W = 48;
  localparam int PHASE_W = 5;
  localparam int COUNT_W = 5;
  localparam int PLEFT_W = 16;

  // Parse phases: 0 is gap check and preamble, 1..15 header fields, then payload and CRC.
  localparam logic [PHASE_W-1:0] PH_GAP     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_LASTHDR = 5'd15;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 5'd16;
  localparam logic [PHASE_W-1:0] PH_CRC     = 5'd17;

  // Field codes of the payload and CRC phases.
  localparam logic [CODE_W-1:0] CODE_PAYLOAD = 5'd15;
  localparam logic [CODE_W-1:0] CODE_CRC     = 5'd16;

  // Character counts.
  localparam logic [COUNT_W-1:0] GAP_CHARS      = 5'd8;
  localparam logic [COUNT_W-1:0] PREAMBLE_CHARS = 5'd16;
  localparam logic [COUNT_W-1:0] PAYLOAD_CHARS  = 5'd2;
  localparam logic [COUNT_W-1:0] CRC_CHARS      = 5'd8;

  // Preamble, header and CRC bytes counted in the length field.
  localparam logic [PLEFT_W-1:0] HDR_BYTES_WITH_CRC = 16'd42;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEVEN   = 8'h37;
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;

  // One result item.
  typedef struct packed {
    logic [CODE_W-1:0]  field_code;
    logic [VALUE_W-1:0] field_value;
    logic               bad_digit;
    logic               short_length;
  } result_t;

  // Hex characters in each header field, indexed by phase.
  function automatic logic [COUNT_W-1:0] hdr_chars(input logic [3:0] phase);
    logic [COUNT_W-1:0] n;
    unique case (phase)
      4'd1, 4'd2:                      n = 5'd12;
      4'd3, 4'd6, 4'd7, 4'd8, 4'd11:   n = 5'd4;
      4'd4, 4'd5, 4'd9, 4'd10, 4'd12,
      4'd13, 4'd14, 4'd15:             n = 5'd2;
      default:                         n = 5'd0;
    endcase
    return n;
  endfunction

  // Nibble value of a hex character; anything else reads as zero and is flagged.
  function automatic logic [4:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    logic [4:0] r;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      r = {1'b0, d[3:0]};
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      d = c - CH_LOW_A + 8'd10;
      r = {1'b0, d[3:0]};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 8'd10;
      r = {1'b0, d[3:0]};
    end else begin
      r = {1'b1, 4'h0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/htfp_char_if.sv
// Request channel carrying one ASCII character per request.
// Depends on htfp_pkg for the character width.
interface htfp_char_if;
  logic                       valid;
  logic                       ready;
  logic [htfp_pkg::CHAR_W-1:0] in_char;

  modport source(output valid, output in_char, input ready);
  modport sink(input valid, input in_char, output ready);
endinterface

FILE: rtl/htfp_field_if.sv
// Result channel carrying one completed frame field per request.
// Depends on htfp_pkg for the field widths.
interface htfp_field_if;
  logic                         valid;
  logic                         ready;
  logic [htfp_pkg::CODE_W-1:0]  field_code;
  logic [htfp_pkg::VALUE_W-1:0] field_value;
  logic                         bad_digit;
  logic                         short_length;

  modport source(output valid, output field_code, output field_value,
                 output bad_digit, output short_length, input ready);
  modport sink(input valid, input field_code, input field_value,
               input bad_digit, input short_length, output ready);
endinterface

FILE: rtl/htfp_in_stage.sv
// Input register of the parser: holds one accepted character until it is parsed.
// Depends on htfp_pkg and htfp_char_if.
module htfp_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  htfp_char_if.sink                   chars,
  input  logic                        advance,
  output logic                        held_valid,
  output logic [htfp_pkg::CHAR_W-1:0] held_char
);
  import htfp_pkg::*;

  // The register frees up whenever its character moves on to the parse step.
  assign chars.ready = !held_valid || advance;

  // Capture a new request or drain the held one.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      held_char <= chars.in_char;
    end
  end

endmodule

FILE: rtl/htfp_step.sv
// Parse state and the per-character update: gap check, preamble, fields, payload, CRC.
// Depends on htfp_pkg.
module htfp_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [htfp_pkg::CHAR_W-1:0] in_char,
  output logic                        has_result,
  output htfp_pkg::result_t           result
);
  import htfp_pkg::*;

  logic [PHASE_W-1:0] parse_phase, parse_phase_next;
  logic [COUNT_W-1:0] chars_in_field, chars_in_field_next;
  logic [PLEFT_W-1:0] payload_left, payload_left_next;
  logic [VALUE_W-1:0] value_accumulator, value_accumulator_next;
  logic               field_bad_seen, field_bad_seen_next;
  logic               gap_still_matching, gap_still_matching_next;

  // Next-state and result logic for one character.
  always_comb begin
    logic [PHASE_W-1:0] ph;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] need;
    logic [4:0]         nib;
    logic [VALUE_W-1:0] acc;
    logic               bad;
    logic               match;
    logic [PLEFT_W-1:0] pleft;
    logic [CHAR_W-1:0]  expect_ch;

    parse_phase_next        = parse_phase;
    chars_in_field_next     = chars_in_field;
    payload_left_next       = payload_left;
    value_accumulator_next  = value_accumulator;
    field_bad_seen_next     = field_bad_seen;
    gap_still_matching_next = gap_still_matching;
    has_result              = 1'b0;
    result                  = '0;

    ph        = (parse_phase > PH_CRC) ? PH_GAP : parse_phase;
    cnt_inc   = chars_in_field + 5'd1;
    nib       = nibble_of(in_char);
    acc       = {value_accumulator[VALUE_W-5:0], nib[3:0]};
    bad       = field_bad_seen | nib[4];
    match     = gap_still_matching;
    pleft     = payload_left;
    expect_ch = chars_in_field[0] ? CH_SEVEN : CH_ZERO;
    need      = hdr_chars(ph[3:0]);

    if (in_char == CH_SPACE || in_char == CH_NEWLINE) begin
      // Dropped characters leave everything as it is.
    end else if (ph == PH_GAP) begin
      // Gap check over the first group, then the rest of the preamble.
      if (chars_in_field < GAP_CHARS && in_char != expect_ch) begin
        match = 1'b0;
      end
      parse_phase_next        = ph;
      gap_still_matching_next = match;
      chars_in_field_next     = cnt_inc;
      if (cnt_inc == GAP_CHARS && match) begin
        chars_in_field_next = '0;
      end else if (cnt_inc >= PREAMBLE_CHARS) begin
        chars_in_field_next     = '0;
        gap_still_matching_next = 1'b1;
        parse_phase_next        = PH_FIRST;
      end
    end else begin
      // Shift the digit in and close the field when it is complete.
      if (ph == PH_PAYLOAD) begin
        need = PAYLOAD_CHARS;
      end else if (ph == PH_CRC) begin
        need = CRC_CHARS;
      end
      parse_phase_next       = ph;
      value_accumulator_next = acc;
      field_bad_seen_next    = bad;
      chars_in_field_next    = cnt_inc;
      if (cnt_inc >= need) begin
        has_result               = 1'b1;
        result.field_value       = acc;
        result.bad_digit         = bad;
        result.short_length      = 1'b0;
        if (ph == PH_PAYLOAD) begin
          result.field_code = CODE_PAYLOAD;
        end else if (ph == PH_CRC) begin
          result.field_code = CODE_CRC;
        end else begin
          result.field_code = ph - 5'd1;
        end

        if (ph == PH_LENGTH) begin
          if (acc[PLEFT_W-1:0] < HDR_BYTES_WITH_CRC) begin
            result.short_length = 1'b1;
            pleft = '0;
          end else begin
            pleft = acc[PLEFT_W-1:0] - HDR_BYTES_WITH_CRC;
          end
        end

        if (ph == PH_LASTHDR) begin
          parse_phase_next = (pleft != '0) ? PH_PAYLOAD : PH_CRC;
        end else if (ph == PH_PAYLOAD) begin
          if (pleft != '0) begin
            pleft = pleft - 16'd1;
          end
          parse_phase_next = (pleft != '0) ? PH_PAYLOAD : PH_CRC;
        end else if (ph == PH_CRC) begin
          parse_phase_next        = PH_GAP;
          gap_still_matching_next = 1'b1;
        end else begin
          parse_phase_next = ph + 5'd1;
        end

        payload_left_next      = pleft;
        chars_in_field_next    = '0;
        value_accumulator_next = '0;
        field_bad_seen_next    = 1'b0;
      end
    end
  end

  // State registers, updated once per parsed character.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_GAP;
      chars_in_field     <= '0;
      payload_left       <= '0;
      value_accumulator  <= '0;
      field_bad_seen     <= 1'b0;
      gap_still_matching <= 1'b1;
    end else if (fire) begin
      parse_phase        <= parse_phase_next;
      chars_in_field     <= chars_in_field_next;
      payload_left       <= payload_left_next;
      value_accumulator  <= value_accumulator_next;
      field_bad_seen     <= field_bad_seen_next;
      gap_still_matching <= gap_still_matching_next;
    end
  end

endmodule

FILE: rtl/htfp_out_stage.sv
// Result register of the parser: holds one completed field until the receiver takes it.
// Depends on htfp_pkg and htfp_field_if.
module htfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              has_result,
  input  htfp_pkg::result_t result,
  output logic              advance,
  htfp_field_if.source      fields
);
  import htfp_pkg::*;

  logic    out_valid;
  result_t out_data;

  // The parse step may run whenever the register is empty or being emptied.
  assign advance = !out_valid || fields.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_data <= result;
    end
  end

  // Drive the result channel from the register.
  assign fields.valid        = out_valid;
  assign fields.field_code   = out_data.field_code;
  assign fields.field_value  = out_data.field_value;
  assign fields.bad_digit    = out_data.bad_digit;
  assign fields.short_length = out_data.short_length;

endmodule

FILE: rtl/hex_text_fronthaul_frame_parser.sv
// Top level of the hex text fronthaul frame parser.
// Depends on htfp_pkg, htfp_char_if, htfp_field_if, htfp_in_stage, htfp_step, htfp_out_stage.
//
// Usage:
//   chars  : request channel, one ASCII character of a hex text frame dump per request.
//   fields : result channel, one completed field per request (header field, payload byte,
//            or CRC), with its code, right-aligned value and error flags.
//   Spaces and newlines are dropped; gap groups and the preamble give no result.
//   A character accepted into the input register is parsed from there, and a field
//   completed by it is written to the result register and offered on the result channel
//   from that register.
//   Throughput: one character per cycle while the receiver takes results, set by the
//   state update between the input register and the result register.
//   Reset (rst, synchronous, active high) empties both registers and returns the parser
//   to the gap check at frame start.
//   When the receiver stalls, the held result stays put, the parse step stops, and the
//   input register takes one more character before the request channel stalls in turn.
module hex_text_fronthaul_frame_parser (
  input  logic         clk,
  input  logic         rst,
  htfp_char_if.sink    chars,
  htfp_field_if.source fields
);
  import htfp_pkg::*;

  logic              advance;
  logic              held_valid;
  logic [CHAR_W-1:0] held_char;
  logic              fire;
  logic              has_result;
  result_t           result;

  // A held character is parsed when the result register can take its outcome.
  assign fire = held_valid && advance;

  htfp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .advance    (advance),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  htfp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .in_char    (held_char),
    .has_result (has_result),
    .result     (result)
  );

  htfp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .has_result (has_result),
    .result     (result),
    .advance    (advance),
    .fields     (fields)
  );

endmodule

FILE: tb/sv/tb_hex_text_fronthaul_frame_parser.sv
// Self-checking testbench for the hex text fronthaul frame parser.
// Needs htfp_pkg, htfp_char_if, htfp_field_if and the parser RTL; builds a hex text
// stream of frames, predicts every emitted field and compares it with the block's output.
`timescale 1ns / 1ps

module tb_hex_text_fronthaul_frame_parser;
  import htfp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_CHARS = 350;
  localparam int MAX_PRINTED  = 40;

  // Preamble filler and start-of-frame delimiter characters.
  localparam logic [CHAR_W-1:0] PRE_FILL = 8'h35;
  localparam logic [CHAR_W-1:0] PRE_SFD  = 8'h44;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ODD} fill_style_t;

  // Frame field predictor and result queue.
  class field_scoreboard;
    logic [PHASE_W-1:0] phase;
    int unsigned        taken;
    logic [PLEFT_W-1:0] bytes_left;
    logic [VALUE_W-1:0] acc;
    bit                 bad_seen;
    bit                 gap_ok;
    result_t            expected_fields[$];
    int                 errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase      = PH_GAP;
      taken      = 0;
      bytes_left = '0;
      acc        = '0;
      bad_seen   = 1'b0;
      gap_ok     = 1'b1;
      expected_fields.delete();
    endfunction

    // Hex digits per header field, indexed by phase.
    function int unsigned digits_for(input logic [PHASE_W-1:0] ph);
      case (ph)
        5'd1, 5'd2:                            return 12;
        5'd3, 5'd6, 5'd7, 5'd8, 5'd11:         return 4;
        5'd4, 5'd5, 5'd9, 5'd10, 5'd12, 5'd13,
        5'd14, 5'd15:                          return 2;
        default:                               return 0;
      endcase
    endfunction

    // Returns 1 for a valid hex digit; anything else reads as nibble zero.
    function bit digit_of(input logic [CHAR_W-1:0] c, output logic [3:0] nib);
      nib = 4'h0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        nib = 4'(c - CH_ZERO);
        return 1'b1;
      end
      if (c >= CH_LOW_A && c <= CH_LOW_F) begin
        nib = 4'(c - CH_LOW_A + 8'd10);
        return 1'b1;
      end
      if (c >= CH_UP_A && c <= CH_UP_F) begin
        nib = 4'(c - CH_UP_A + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advances the parser state by one character; returns 1 when a field completes.
    function bit parse_char(input logic [CHAR_W-1:0] c, output result_t r);
      logic [3:0]         nib;
      logic [PLEFT_W-1:0] len;
      logic [PHASE_W-1:0] next_phase;
      int unsigned        need;
      bit                 short_len;
      r = '0;
      short_len = 1'b0;
      if (c == CH_SPACE || c == CH_NEWLINE) return 1'b0;
      if (phase > PH_CRC) phase = PH_GAP;

      // Gap groups repeat in place; anything else runs on as the preamble.
      if (phase == PH_GAP) begin
        if (taken < GAP_CHARS && c != (taken[0] ? CH_SEVEN : CH_ZERO)) gap_ok = 1'b0;
        taken++;
        if (taken == GAP_CHARS && gap_ok) begin
          taken = 0;
        end else if (taken >= PREAMBLE_CHARS) begin
          taken  = 0;
          gap_ok = 1'b1;
          phase  = PH_FIRST;
        end
        return 1'b0;
      end

      if (!digit_of(c, nib)) bad_seen = 1'b1;
      acc = {acc[VALUE_W-5:0], nib};
      taken++;
      if (phase == PH_PAYLOAD) need = PAYLOAD_CHARS;
      else if (phase == PH_CRC) need = CRC_CHARS;
      else need = digits_for(phase);
      if (taken < need) return 1'b0;

      if (phase == PH_PAYLOAD) r.field_code = CODE_PAYLOAD;
      else if (phase == PH_CRC) r.field_code = CODE_CRC;
      else r.field_code = CODE_W'(phase - PH_FIRST);

      // The length field sets how many payload bytes follow the header.
      if (phase == PH_LENGTH) begin
        len = acc[PLEFT_W-1:0];
        if (len < HDR_BYTES_WITH_CRC) begin
          short_len  = 1'b1;
          bytes_left = '0;
        end else begin
          bytes_left = len - HDR_BYTES_WITH_CRC;
        end
      end

      if (phase == PH_LASTHDR) begin
        next_phase = (bytes_left != 0) ? PH_PAYLOAD : PH_CRC;
      end else if (phase == PH_PAYLOAD) begin
        if (bytes_left != 0) bytes_left--;
        next_phase = (bytes_left != 0) ? PH_PAYLOAD : PH_CRC;
      end else if (phase == PH_CRC) begin
        next_phase = PH_GAP;
        gap_ok     = 1'b1;
      end else begin
        next_phase = phase + 5'd1;
      end

      r.field_value  = acc;
      r.bad_digit    = bad_seen;
      r.short_length = short_len;
      phase    = next_phase;
      taken    = 0;
      acc      = '0;
      bad_seen = 1'b0;
      return 1'b1;
    endfunction

    function void note_char(input logic [CHAR_W-1:0] c);
      result_t r;
      if (parse_char(c, r)) expected_fields.push_back(r);
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTED) $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    task check_field(input result_t got);
      result_t want;
      if (expected_fields.size() == 0) begin
        report($sformatf("field code %0d value %h arrived with none expected",
                         got.field_code, got.field_value));
        return;
      end
      want = expected_fields.pop_front();
      if (got.field_code !== want.field_code)
        report($sformatf("field_code %0d, expected %0d", got.field_code, want.field_code));
      if (got.field_value !== want.field_value)
        report($sformatf("field %0d: field_value %h, expected %h",
                         want.field_code, got.field_value, want.field_value));
      if (got.bad_digit !== want.bad_digit)
        report($sformatf("field %0d: bad_digit %b, expected %b",
                         want.field_code, got.bad_digit, want.bad_digit));
      if (got.short_length !== want.short_length)
        report($sformatf("field %0d: short_length %b, expected %b",
                         want.field_code, got.short_length, want.short_length));
    endtask
  endclass

  logic clk;
  logic rst;
  htfp_char_if  char_link();
  htfp_field_if field_link();

  hex_text_fronthaul_frame_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (char_link),
    .fields (field_link)
  );

  field_scoreboard   field_check  = new();
  field_scoreboard   text_tracker = new();
  logic [CHAR_W-1:0] text_chars[$];
  int                counted_chars = 0;
  int                sep_pct = 0;
  int                odd_idx = 0;
  int                cycle_count = 0;
  int                stall_mode = 0;
  int                mode_left = 0;
  int                hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls: modes of always ready, random, periodic and long holds.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: field_link.ready <= 1'b1;
      1: field_link.ready <= ($urandom_range(0, 3) != 0);
      2: field_link.ready <= ((cycle_count % 5) < 2);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          field_link.ready <= 1'b0;
        end else begin
          field_link.ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Watch both channels: feed accepted characters to the predictor, check results.
  always @(posedge clk) begin : watch
    result_t seen;
    if (!rst) begin
      if (char_link.valid && char_link.ready) field_check.note_char(char_link.in_char);
      if (field_link.valid && field_link.ready) begin
        seen.field_code   = field_link.field_code;
        seen.field_value  = field_link.field_value;
        seen.bad_digit    = field_link.bad_digit;
        seen.short_length = field_link.short_length;
        field_check.check_field(seen);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + CHAR_W'(nib);
    return (($urandom_range(0, 1) != 0) ? CH_UP_A : CH_LOW_A) + CHAR_W'(nib) - 8'd10;
  endfunction

  function automatic logic [CHAR_W-1:0] random_nonsep();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] non_hex();
    logic [CHAR_W-1:0] c;
    logic [3:0]        nib;
    do c = random_nonsep(); while (text_tracker.digit_of(c, nib));
    return c;
  endfunction

  // Characters at the edges of the hex ranges, control codes and the top bit set.
  function automatic logic [CHAR_W-1:0] odd_char(input int idx);
    case (idx % 18)
      0:  return 8'h00;
      1:  return 8'hFF;
      2:  return 8'h0D;
      3:  return 8'h2F;
      4:  return CH_ZERO;
      5:  return CH_NINE;
      6:  return 8'h3A;
      7:  return 8'h40;
      8:  return CH_UP_A;
      9:  return CH_UP_F;
      10: return 8'h47;
      11: return 8'h60;
      12: return CH_LOW_A;
      13: return CH_LOW_F;
      14: return 8'h67;
      15: return 8'h7F;
      16: return 8'h80;
      default: return 8'h09;
    endcase
  endfunction

  // Appends one character; a second parser copy tracks where the stream stands.
  task automatic push_char(input logic [CHAR_W-1:0] c);
    result_t unused;
    text_chars.push_back(c);
    void'(text_tracker.parse_char(c, unused));
    if (c != CH_SPACE && c != CH_NEWLINE) counted_chars++;
    if ($urandom_range(0, 99) < sep_pct)
      text_chars.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NEWLINE);
  endtask

  // One character of a header field, payload byte or CRC. Length digits are only ever
  // spoiled by non-hex characters, which can only shrink the payload.
  task automatic emit_field_char(input fill_style_t fill, input logic [15:0] len_value,
                                 input int bad_pct);
    logic [15:0]       shifted;
    logic [CHAR_W-1:0] c;
    if (text_tracker.phase == PH_LENGTH) begin
      shifted = len_value >> (4 * (3 - text_tracker.taken));
      c = hex_char(shifted[3:0]);
      if ($urandom_range(0, 99) < bad_pct) c = non_hex();
    end else begin
      case (fill)
        FILL_ZERO: c = hex_char(4'h0);
        FILL_ONES: c = hex_char(4'hF);
        FILL_ODD: begin
          c = odd_char(odd_idx);
          odd_idx++;
        end
        default: c = hex_char(4'($urandom_range(0, 15)));
      endcase
      if ($urandom_range(0, 99) < bad_pct) c = random_nonsep();
    end
    push_char(c);
  endtask

  // A whole frame: gap groups, preamble, header, payload and CRC.
  task automatic emit_frame(input int gaps, input bit broken_gap, input bit noisy_pre,
                            input fill_style_t fill, input logic [15:0] len_value,
                            input int bad_pct);
    int                spoil;
    logic [CHAR_W-1:0] c;
    for (int g = 0; g < gaps && text_tracker.phase == PH_GAP; g++) begin
      spoil = (broken_gap && g == gaps - 1) ? $urandom_range(0, 7) : 8;
      for (int k = 0; k < 8; k++) begin
        c = k[0] ? CH_SEVEN : CH_ZERO;
        if (k == spoil) begin
          if ($urandom_range(0, 1) != 0) c = k[0] ? CH_ZERO : CH_SEVEN;
          else c = non_hex();
        end
        push_char(c);
      end
    end
    while (text_tracker.phase == PH_GAP) begin
      if (noisy_pre) push_char(random_nonsep());
      else push_char((text_tracker.taken == 15) ? PRE_SFD : PRE_FILL);
    end
    while (text_tracker.phase != PH_GAP) emit_field_char(fill, len_value, bad_pct);
  endtask

  task automatic build_text();
    int          target;
    int          pick;
    fill_style_t fill;
    logic [15:0] len_value;
    // Directed frames: all-ones fields, a spoiled gap group with odd characters and a
    // zero length, a length just short of the header, a header-only frame with a noisy
    // preamble, and one longer payload.
    sep_pct = 30;
    emit_frame(2, 1'b0, 1'b0, FILL_ONES, 16'h002C, 0);
    emit_frame(1, 1'b1, 1'b0, FILL_ODD,  16'h0000, 0);
    emit_frame(0, 1'b0, 1'b0, FILL_ZERO, 16'h0029, 0);
    emit_frame(3, 1'b0, 1'b1, FILL_RANDOM, 16'h002A, 0);
    sep_pct = 5;
    emit_frame(1, 1'b0, 1'b0, FILL_RANDOM, 16'h0100, 0);

    // Random frames, mostly well formed with small payloads.
    target = counted_chars + RANDOM_CHARS;
    while (counted_chars < target) begin
      sep_pct = $urandom_range(0, 12);
      pick = $urandom_range(0, 99);
      if (pick < 70) fill = FILL_RANDOM;
      else if (pick < 80) fill = FILL_ZERO;
      else if (pick < 90) fill = FILL_ONES;
      else fill = FILL_ODD;
      pick = $urandom_range(0, 99);
      if (pick < 12) len_value = 16'($urandom_range(0, 41));
      else if (pick < 95) len_value = 16'(42 + $urandom_range(0, 8));
      else len_value = 16'(42 + $urandom_range(9, 40));
      emit_frame($urandom_range(0, 3), ($urandom_range(0, 99) < 15),
                 ($urandom_range(0, 99) < 10), fill, len_value,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0);
    end

    // A frame cut short at the end of the stream.
    emit_frame(1, 1'b0, 1'b0, FILL_RANDOM, 16'h002E, 0);
    for (int k = 0; k < 16 + 30; k++) push_char(hex_char(4'($urandom_range(1, 15))));
  endtask

  // Sends the character stream in bursts with random gaps between them.
  task automatic send_text();
    int burst;
    int idle;
    while (text_chars.size() > 0) begin
      burst = $urandom_range(1, 64);
      while (burst > 0 && text_chars.size() > 0) begin
        @(negedge clk);
        char_link.valid   <= 1'b1;
        char_link.in_char <= text_chars[0];
        do @(posedge clk); while (!char_link.ready);
        text_chars.delete(0);
        burst--;
      end
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        @(negedge clk);
        char_link.valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    char_link.valid <= 1'b0;
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    char_link.valid   = 1'b0;
    char_link.in_char = '0;
    field_link.ready  = 1'b0;
    build_text();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text();
    while (field_check.expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (field_check.expected_fields.size() != 0)
      field_check.report($sformatf("%0d expected fields never arrived",
                                   field_check.expected_fields.size()));

    if (field_check.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/htfp_pkg.sv
rtl/htfp_char_if.sv
rtl/htfp_field_if.sv
rtl/htfp_in_stage.sv
rtl/htfp_step.sv
rtl/htfp_out_stage.sv
rtl/hex_text_fronthaul_frame_parser.sv
tb/sv/tb_hex_text_fronthaul_frame_parser.sv
